FILE: rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg: UTF-8 stream decoder package
// Shared widths, decoder state and result types for the decoder and its
// channel interfaces.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int COUNT_BITS = 16;
	localparam int BYTE_BITS  = 8;
	localparam int CP_BITS    = 31;
	localparam int LEN_BITS   = 3;
	localparam int TOTAL_BITS = 16;

	localparam logic [BYTE_BITS-1:0] ASCII_MAX  = 8'h7F;
	localparam logic [BYTE_BITS-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_BITS-1:0] CONT_MARK  = 8'h80;
	localparam logic [BYTE_BITS-1:0] CONT_BITS  = 8'h3F;
	localparam logic [BYTE_BITS-1:0] LEAD2_BITS = 8'h1F;
	localparam logic [BYTE_BITS-1:0] LEAD3_BITS = 8'h0F;
	localparam logic [BYTE_BITS-1:0] LEAD4_BITS = 8'h07;
	localparam logic [BYTE_BITS-1:0] LEAD5_BITS = 8'h03;
	localparam logic [BYTE_BITS-1:0] LEAD6_BITS = 8'h01;
	localparam logic [BYTE_BITS-1:0] END_BYTE   = 8'h00;

	localparam logic [LEN_BITS-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_BITS-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_BITS-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_BITS-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_BITS-1:0] LEN_FOUR = 3'd4;
	localparam logic [LEN_BITS-1:0] LEN_FIVE = 3'd5;
	localparam logic [LEN_BITS-1:0] LEN_SIX  = 3'd6;

	typedef struct packed {
		logic [LEN_BITS-1:0]   bytes_left;
		logic [LEN_BITS-1:0]   seq_total;
		logic [CP_BITS-1:0]    accum_value;
		logic [COUNT_BITS-1:0] char_counter;
		logic                  error_seen;
	} u8d_state_t;

	typedef struct packed {
		logic [CP_BITS-1:0]    code_point;
		logic [LEN_BITS-1:0]   seq_bytes;
		logic                  bad_sequence;
		logic                  end_of_string;
		logic [TOTAL_BITS-1:0] char_total;
		logic                  string_valid;
	} u8d_result_t;

endpackage

FILE: rtl/u8d_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_in_if: byte channel
// Valid/ready channel carrying one string byte per word.
// ----------------------------------------------------------------------------
interface u8d_in_if;
	logic                           valid;
	logic                           ready;
	logic [u8d_pkg::BYTE_BITS-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/u8d_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_out_if: decoded character channel
// Valid/ready channel carrying one decoder result per word.
// ----------------------------------------------------------------------------
interface u8d_out_if;
	logic                            valid;
	logic                            ready;
	logic [u8d_pkg::CP_BITS-1:0]    code_point;
	logic [u8d_pkg::LEN_BITS-1:0]   seq_bytes;
	logic                            bad_sequence;
	logic                            end_of_string;
	logic [u8d_pkg::TOTAL_BITS-1:0] char_total;
	logic                            string_valid;

	modport source (output valid, output code_point, output seq_bytes,
		output bad_sequence, output end_of_string, output char_total,
		output string_valid, input ready);
	modport sink   (input valid, input code_point, input seq_bytes,
		input bad_sequence, input end_of_string, input char_total,
		input string_valid, output ready);
endinterface

FILE: rtl/u8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_step: UTF-8 decode step
// Next decoder state and optional result for one byte.
// ----------------------------------------------------------------------------
module u8d_step (
	input  u8d_pkg::u8d_state_t               state,
	input  logic [u8d_pkg::BYTE_BITS-1:0]     in_byte,
	output u8d_pkg::u8d_state_t               next_state,
	output logic                              emit,
	output u8d_pkg::u8d_result_t              result
);

	logic [u8d_pkg::COUNT_BITS-1:0] count_inc;
	logic [u8d_pkg::CP_BITS-1:0]    accum_next;
	logic [u8d_pkg::LEN_BITS-1:0]   left_next;

	assign count_inc  = (&state.char_counter) ? state.char_counter
		: state.char_counter + u8d_pkg::COUNT_BITS'(1);
	assign accum_next = {state.accum_value[u8d_pkg::CP_BITS-7:0],
		in_byte[5:0]};
	assign left_next  = state.bytes_left - u8d_pkg::LEN_BITS'(1);

	always_comb begin
		next_state = state;
		emit       = 1'b0;
		result     = '0;
		result.char_total = u8d_pkg::TOTAL_BITS'(state.char_counter);

		if (in_byte == u8d_pkg::END_BYTE) begin
			emit                 = 1'b1;
			result.end_of_string = 1'b1;
			result.bad_sequence  = !state.error_seen && (state.bytes_left != u8d_pkg::LEN_NONE);
			result.string_valid  = !state.error_seen && (state.bytes_left == u8d_pkg::LEN_NONE);
			next_state           = '0;
		end else if (state.error_seen) begin
			emit = 1'b0;
		end else if (state.bytes_left == u8d_pkg::LEN_NONE) begin
			if (in_byte <= u8d_pkg::ASCII_MAX) begin
				emit                    = 1'b1;
				next_state.char_counter = count_inc;
				result.code_point       = u8d_pkg::CP_BITS'(in_byte);
				result.seq_bytes        = u8d_pkg::LEN_ONE;
				result.char_total       = u8d_pkg::TOTAL_BITS'(count_inc);
			end else if (in_byte inside {[8'hC0:8'hDF]}) begin
				next_state.seq_total   = u8d_pkg::LEN_TWO;
				next_state.accum_value = u8d_pkg::CP_BITS'(in_byte & u8d_pkg::LEAD2_BITS);
			end else if (in_byte inside {[8'hE0:8'hEF]}) begin
				next_state.seq_total   = u8d_pkg::LEN_THREE;
				next_state.accum_value = u8d_pkg::CP_BITS'(in_byte & u8d_pkg::LEAD3_BITS);
			end else if (in_byte inside {[8'hF0:8'hF7]}) begin
				next_state.seq_total   = u8d_pkg::LEN_FOUR;
				next_state.accum_value = u8d_pkg::CP_BITS'(in_byte & u8d_pkg::LEAD4_BITS);
			end else if (in_byte inside {[8'hF8:8'hFB]}) begin
				next_state.seq_total   = u8d_pkg::LEN_FIVE;
				next_state.accum_value = u8d_pkg::CP_BITS'(in_byte & u8d_pkg::LEAD5_BITS);
			end else if (in_byte inside {[8'hFC:8'hFD]}) begin
				next_state.seq_total   = u8d_pkg::LEN_SIX;
				next_state.accum_value = u8d_pkg::CP_BITS'(in_byte & u8d_pkg::LEAD6_BITS);
			end else begin
				emit                  = 1'b1;
				next_state.error_seen = 1'b1;
				result.bad_sequence   = 1'b1;
			end
			if (!emit) begin
				next_state.bytes_left = next_state.seq_total - u8d_pkg::LEN_BITS'(1);
			end
		end else if ((in_byte & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_MARK) begin
			emit                   = 1'b1;
			next_state.error_seen  = 1'b1;
			next_state.bytes_left  = u8d_pkg::LEN_NONE;
			next_state.seq_total   = u8d_pkg::LEN_NONE;
			next_state.accum_value = '0;
			result.bad_sequence    = 1'b1;
		end else if (left_next != u8d_pkg::LEN_NONE) begin
			next_state.accum_value = accum_next;
			next_state.bytes_left  = left_next;
		end else begin
			emit                    = 1'b1;
			next_state.bytes_left   = u8d_pkg::LEN_NONE;
			next_state.seq_total    = u8d_pkg::LEN_NONE;
			next_state.accum_value  = '0;
			next_state.char_counter = count_inc;
			result.code_point       = accum_next;
			result.seq_bytes        = state.seq_total;
			result.char_total       = u8d_pkg::TOTAL_BITS'(count_inc);
		end
	end

endmodule

FILE: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: UTF-8 stream decoder, six-byte form
// Decodes a zero-terminated byte string into code points with error and
// end-of-string reporting.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream takes one string byte per word; a zero byte ends the string.
//   char_stream gives one word per completed character, per first error and
//   per terminating zero; lead and middle bytes and bytes after an error
//   give no word.
//   Path: each accepted byte passes the input register; its result word is then
//   held in the result register.
//   Throughput: one byte per cycle unless char_stream stalls; the decoder
//   state update between the input and result registers is the only loop.
//   Stall: while char_stream is held off a full result register, the input
//   register still drains bytes that give no word; otherwise byte_stream
//   ready drops once the input register is also occupied.
//   Reset: arst_n clears the decoder state, counter and both valid flags;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u8d_in_if.sink     byte_stream,
	u8d_out_if.source  char_stream
);

	logic                           valid_s1;
	logic [u8d_pkg::BYTE_BITS-1:0] byte_s1;
	u8d_pkg::u8d_state_t            state_q;
	u8d_pkg::u8d_state_t            state_next;
	u8d_pkg::u8d_result_t           result;
	u8d_pkg::u8d_result_t           res_q;
	logic                           out_valid_q;
	logic                           emit;
	logic                           advance;

	u8d_step u_step (
		.state      (state_q),
		.in_byte    (byte_s1),
		.next_state (state_next),
		.emit       (emit),
		.result     (result)
	);

	assign advance = valid_s1 && (!emit || !out_valid_q || char_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (byte_stream.valid && byte_stream.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (char_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.in_byte;
		end
		if (advance && emit) begin
			res_q <= result;
		end
	end

	assign char_stream.valid         = out_valid_q;
	assign char_stream.code_point    = res_q.code_point;
	assign char_stream.seq_bytes     = res_q.seq_bytes;
	assign char_stream.bad_sequence  = res_q.bad_sequence;
	assign char_stream.end_of_string = res_q.end_of_string;
	assign char_stream.char_total    = res_q.char_total;
	assign char_stream.string_valid  = res_q.string_valid;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == u8d_pkg::END_BYTE |=>
		state_q.char_counter == '0 && !state_q.error_seen &&
		state_q.bytes_left == u8d_pkg::LEN_NONE)
		else $error("state not cleared after end of string");

	a_no_seq_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_seen |-> state_q.bytes_left == u8d_pkg::LEN_NONE)
		else $error("sequence open after error");

	a_left_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_left != u8d_pkg::LEN_NONE |-> state_q.bytes_left < state_q.seq_total)
		else $error("continuation count exceeds sequence length");

	a_char_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.bad_sequence && !res_q.end_of_string |->
		res_q.seq_bytes != u8d_pkg::LEN_NONE && res_q.seq_bytes <= u8d_pkg::LEN_SIX)
		else $error("character word with bad length");

	a_end_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.end_of_string || res_q.bad_sequence) |->
		res_q.code_point == '0 && res_q.seq_bytes == u8d_pkg::LEN_NONE)
		else $error("end or error word carries a character");

endmodule
